// ===== hdl/tcfw_pkg.sv =====
`timescale 1ns / 1ps
// tcfw_pkg: transaction types, request codes and character constants shared
// by every module of the text console frame writer except tcfw_ram. No dependencies.
package tcfw_pkg;

  // Request codes carried in req_type
  localparam logic [2:0] REQ_CHAR   = 3'd0;
  localparam logic [2:0] REQ_CURSOR = 3'd1;
  localparam logic [2:0] REQ_CLEAR  = 3'd2;
  localparam logic [2:0] REQ_LOAD   = 3'd3;
  localparam logic [2:0] REQ_READ   = 3'd4;

  // Character set
  localparam logic [7:0] FIRST_CODE   = 8'd32;
  localparam logic [7:0] LAST_CODE    = 8'd126;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam int         GLYPH_COUNT  = 95;
  localparam logic [7:0] BLANK_COLUMN = 8'h00;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] char_code;
    logic [7:0] row;
    logic [8:0] column;
    logic [6:0] glyph_index;
    logic [2:0] glyph_column;
    logic [7:0] glyph_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [4:0] text_row;
    logic [7:0] text_col;
  } out_item_t;

  // Operation decided by the front end; anything that changes nothing is OP_NOP
  typedef enum logic [2:0] {
    OP_NOP     = 3'd0,
    OP_NEWLINE = 3'd1,
    OP_DRAW    = 3'd2,
    OP_SET     = 3'd3,
    OP_CLEAR   = 3'd4,
    OP_LOAD    = 3'd5,
    OP_READ    = 3'd6
  } op_e;

  typedef struct packed {
    op_e      op;
    in_item_t item;
  } cmd_t;

endpackage

// ===== hdl/tcfw_ram.sv =====
`timescale 1ns / 1ps
// tcfw_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module tcfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/tcfw_fifo.sv =====
`timescale 1ns / 1ps
// tcfw_fifo: two-entry command queue between the front end and the back end.
// Depends on tcfw_pkg.
module tcfw_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tcfw_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output tcfw_pkg::cmd_t data_o
);

  tcfw_pkg::cmd_t entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign data_o  = entry_q[rd_ptr_q];

endmodule

// ===== hdl/tcfw_front.sv =====
`timescale 1ns / 1ps
// tcfw_front: input handshake and request classification into queue commands.
// Depends on tcfw_pkg.
module tcfw_front #(
  parameter int PAGES       = 16,
  parameter int COLUMNS     = 256,
  parameter int GLYPH_WIDTH = 5
) (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tcfw_pkg::in_item_t in_data_i,
  input  logic               boot_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output tcfw_pkg::cmd_t     q_data_o
);

  logic in_range;
  logic glyph_ok;

  // Range checks for cursor, read and glyph load positions
  assign in_range = (in_data_i.row < PAGES) && (in_data_i.column < COLUMNS);
  assign glyph_ok = (in_data_i.glyph_index < tcfw_pkg::GLYPH_COUNT) &&
                    (in_data_i.glyph_column < GLYPH_WIDTH);

  always_comb begin
    q_data_o.item = in_data_i;
    q_data_o.op   = tcfw_pkg::OP_NOP;
    case (in_data_i.req_type)
      tcfw_pkg::REQ_CHAR: begin
        if (in_data_i.char_code == tcfw_pkg::NEWLINE_CODE) begin
          q_data_o.op = tcfw_pkg::OP_NEWLINE;
        end else if (in_data_i.char_code inside
                     {[tcfw_pkg::FIRST_CODE:tcfw_pkg::LAST_CODE]}) begin
          q_data_o.op = tcfw_pkg::OP_DRAW;
        end
      end
      tcfw_pkg::REQ_CURSOR: begin
        if (in_range) begin
          q_data_o.op = tcfw_pkg::OP_SET;
        end
      end
      tcfw_pkg::REQ_CLEAR: begin
        q_data_o.op = tcfw_pkg::OP_CLEAR;
      end
      tcfw_pkg::REQ_LOAD: begin
        if (glyph_ok) begin
          q_data_o.op = tcfw_pkg::OP_LOAD;
        end
      end
      tcfw_pkg::REQ_READ: begin
        if (in_range) begin
          q_data_o.op = tcfw_pkg::OP_READ;
        end
      end
      default: begin
        q_data_o.op = tcfw_pkg::OP_NOP;
      end
    endcase
  end

  // Nothing is taken while the framebuffer is being swept after reset
  assign in_stall_o = q_full_i || boot_i;
  assign q_push_o   = in_valid_i && !in_stall_o;

endmodule

// ===== hdl/tcfw_back.sv =====
`timescale 1ns / 1ps
// tcfw_back: command sequencer with cursor, framebuffer and font RAMs, and
// the result register. Depends on tcfw_pkg and tcfw_ram.
module tcfw_back #(
  parameter int PAGES       = 16,
  parameter int COLUMNS     = 256,
  parameter int GLYPH_WIDTH = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  tcfw_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output logic                boot_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tcfw_pkg::out_item_t out_data_o
);

  localparam int CELL    = GLYPH_WIDTH + 1;
  localparam int PW      = $clog2(PAGES + 1);
  localparam int CW      = $clog2(COLUMNS);
  localparam int SW      = $clog2(COLUMNS + CELL) + 1;
  localparam int KW      = $clog2(GLYPH_WIDTH + 1);
  localparam int PDEPTH  = PAGES * COLUMNS;
  localparam int PA_W    = $clog2(PDEPTH);
  localparam int GDEPTH  = tcfw_pkg::GLYPH_COUNT * GLYPH_WIDTH;
  localparam int GA_W    = $clog2(GDEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DRAW  = 3'd1;
  localparam logic [2:0] S_CLEAR = 3'd2;
  localparam logic [2:0] S_DONE  = 3'd3;

  logic [2:0]      state_q, state_d;
  logic            boot_q, boot_d;
  logic [PW-1:0]   page_q, page_d;
  logic [CW-1:0]   col_q, col_d;
  logic [PA_W-1:0] clr_q, clr_d;
  logic [KW-1:0]   k_q, k_d;
  logic [PA_W-1:0] base_q, base_d;
  logic [GA_W-1:0] gbase_q, gbase_d;
  logic            rd_q, rd_d;
  logic            out_valid_q, out_valid_d;
  tcfw_pkg::out_item_t out_q, out_d;

  logic            pix_we, pix_re;
  logic [PA_W-1:0] pix_waddr, pix_raddr;
  logic [7:0]      pix_wdata, pix_rdata;
  logic            gly_we, gly_re;
  logic [GA_W-1:0] gly_waddr, gly_raddr;
  logic [7:0]      gly_rdata;

  logic [SW-1:0]   col_sum;
  logic            wrap;
  logic [PW-1:0]   adv_page, eff_page;
  logic [CW-1:0]   eff_col;
  logic            out_free;
  logic [CW+7:0]   col_ext;
  logic [PW+4:0]   page_ext;

  assign col_sum  = SW'(col_q) + SW'(CELL);
  assign wrap     = col_sum >= SW'(COLUMNS);
  assign adv_page = (page_q < PW'(PAGES)) ? page_q + PW'(1) : page_q;
  assign eff_page = wrap ? adv_page : page_q;
  assign eff_col  = wrap ? '0 : col_q;
  assign out_free = !out_valid_q || !out_stall_i;
  assign col_ext  = {8'b0, col_q};
  assign page_ext = {5'b0, page_q};

  always_comb begin
    state_d     = state_q;
    boot_d      = boot_q;
    page_d      = page_q;
    col_d       = col_q;
    clr_d       = clr_q;
    k_d         = k_q;
    base_d      = base_q;
    gbase_d     = gbase_q;
    rd_d        = rd_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    cmd_pop_o   = 1'b0;
    pix_we      = 1'b0;
    pix_waddr   = base_q;
    pix_wdata   = tcfw_pkg::BLANK_COLUMN;
    pix_re      = 1'b0;
    pix_raddr   = PA_W'(cmd_i.item.row * COLUMNS) + PA_W'(cmd_i.item.column);
    gly_we      = 1'b0;
    gly_waddr   = GA_W'(cmd_i.item.glyph_index * GLYPH_WIDTH) +
                  GA_W'(cmd_i.item.glyph_column);
    gly_re      = 1'b0;
    gly_raddr   = gbase_q + GA_W'(k_q);

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          rd_d      = 1'b0;
          state_d   = S_DONE;
          case (cmd_i.op)
            tcfw_pkg::OP_NEWLINE: begin
              page_d = adv_page;
              col_d  = '0;
            end
            tcfw_pkg::OP_DRAW: begin
              page_d = eff_page;
              col_d  = eff_col;
              if (eff_page != PW'(PAGES)) begin
                col_d   = eff_col + CW'(CELL);
                base_d  = PA_W'(eff_page * COLUMNS) + PA_W'(eff_col);
                gbase_d = GA_W'((cmd_i.item.char_code - tcfw_pkg::FIRST_CODE) *
                                GLYPH_WIDTH);
                k_d     = '0;
                state_d = S_DRAW;
              end
            end
            tcfw_pkg::OP_SET: begin
              page_d = PW'(cmd_i.item.row);
              col_d  = CW'(cmd_i.item.column);
            end
            tcfw_pkg::OP_CLEAR: begin
              page_d  = '0;
              col_d   = '0;
              clr_d   = '0;
              state_d = S_CLEAR;
            end
            tcfw_pkg::OP_LOAD: begin
              gly_we = 1'b1;
            end
            tcfw_pkg::OP_READ: begin
              pix_re = 1'b1;
              rd_d   = 1'b1;
            end
            default: begin
              rd_d = 1'b0;
            end
          endcase
        end
      end
      S_DRAW: begin
        // Step 0 writes the spacing column; step k writes glyph column k-1,
        // read from the font RAM one step earlier
        gly_re = k_q < KW'(GLYPH_WIDTH);
        pix_we = 1'b1;
        if (k_q == '0) begin
          pix_waddr = base_q + PA_W'(GLYPH_WIDTH);
          pix_wdata = tcfw_pkg::BLANK_COLUMN;
        end else begin
          pix_waddr = base_q + PA_W'(k_q) - PA_W'(1);
          pix_wdata = gly_rdata;
        end
        k_d = k_q + KW'(1);
        if (k_q == KW'(GLYPH_WIDTH)) begin
          state_d = S_DONE;
        end
      end
      S_CLEAR: begin
        pix_we    = 1'b1;
        pix_waddr = clr_q;
        pix_wdata = tcfw_pkg::BLANK_COLUMN;
        clr_d     = clr_q + PA_W'(1);
        if (clr_q == PA_W'(PDEPTH - 1)) begin
          boot_d  = 1'b0;
          state_d = boot_q ? S_IDLE : S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.read_data    = rd_q ? pix_rdata : 8'h00;
          out_d.text_row     = page_ext[4:0];
          out_d.text_col     = col_ext[7:0];
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      boot_q      <= 1'b1;
      page_q      <= '0;
      col_q       <= '0;
      clr_q       <= '0;
      k_q         <= '0;
      rd_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      boot_q      <= boot_d;
      page_q      <= page_d;
      col_q       <= col_d;
      clr_q       <= clr_d;
      k_q         <= k_d;
      rd_q        <= rd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q  <= base_d;
    gbase_q <= gbase_d;
    out_q   <= out_d;
  end

  tcfw_ram #(
    .WIDTH(8),
    .DEPTH(PDEPTH)
  ) u_pixel_ram (
    .clk_i  (clk_i),
    .we_i   (pix_we),
    .waddr_i(pix_waddr),
    .wdata_i(pix_wdata),
    .re_i   (pix_re),
    .raddr_i(pix_raddr),
    .rdata_o(pix_rdata)
  );

  tcfw_ram #(
    .WIDTH(8),
    .DEPTH(GDEPTH)
  ) u_glyph_ram (
    .clk_i  (clk_i),
    .we_i   (gly_we),
    .waddr_i(gly_waddr),
    .wdata_i(cmd_i.item.glyph_byte),
    .re_i   (gly_re),
    .raddr_i(gly_raddr),
    .rdata_o(gly_rdata)
  );

  assign boot_o      = boot_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/text_console_frame_writer.sv =====
`timescale 1ns / 1ps
// text_console_frame_writer: top level of the text console, front end, command
// queue and back end. Depends on tcfw_pkg, tcfw_front, tcfw_fifo, tcfw_back.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------
//   in      | to block  | in_valid_i / in_stall_o | in_data_i (tcfw_pkg::in_item_t)
//   out     | from block| out_valid_o/out_stall_i | out_data_o (tcfw_pkg::out_item_t)
//
// Every input transaction gives exactly one output transaction, in order.
// In the back end a character draw writes one framebuffer byte per cycle
// through the single write port of the pixel RAM, and a clear zeroes all
// PAGES*COLUMNS framebuffer bytes in a sweep. Reset: an initial zeroing sweep
// of the framebuffer holds in_stall_o high.
// The two-entry queue keeps the input side taking transactions while the back
// end works, and the result register holds a finished result under out_stall_i.
module text_console_frame_writer #(
  parameter int PAGES       = 16,
  parameter int COLUMNS     = 256,
  parameter int GLYPH_WIDTH = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tcfw_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tcfw_pkg::out_item_t out_data_o
);

  // Front end to queue
  logic           q_push;
  tcfw_pkg::cmd_t q_push_data;
  logic           q_full;
  // Queue to back end
  logic           q_pop;
  logic           q_valid;
  tcfw_pkg::cmd_t q_head;
  // Back end busy with the reset sweep
  logic           boot;

  // Classifies each request and range-checks its position fields
  tcfw_front #(
    .PAGES      (PAGES),
    .COLUMNS    (COLUMNS),
    .GLYPH_WIDTH(GLYPH_WIDTH)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .boot_i    (boot),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_data_o  (q_push_data)
  );

  tcfw_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_push_data),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .data_o     (q_head)
  );

  // Cursor, framebuffer, font store and result register
  tcfw_back #(
    .PAGES      (PAGES),
    .COLUMNS    (COLUMNS),
    .GLYPH_WIDTH(GLYPH_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_i      (q_head),
    .cmd_pop_o  (q_pop),
    .boot_o     (boot),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== hdl/tcfw_checker.sv =====
`timescale 1ns / 1ps
// tcfw_checker: port-level assertions on the text console, bound to the top
// level. Depends on tcfw_pkg and text_console_frame_writer.
module tcfw_checker #(
  parameter int PAGES = 16
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input tcfw_pkg::out_item_t out_data_o
);

  logic       in_acc, out_acc;
  logic [2:0] pending_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 3'(in_acc) - 3'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pending_q != 3'd0)
    else $error("result without a pending request");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.text_row <= PAGES)
    else $error("cursor page beyond off-screen value");

endmodule

bind text_console_frame_writer tcfw_checker #(.PAGES(PAGES)) u_tcfw_checker (.*);

// ===== test/tb_text_console_frame_writer.sv =====
`timescale 1ns / 1ps
// tb_text_console_frame_writer: self-checking bench for the text console frame
// writer. Depends on tcfw_pkg and text_console_frame_writer only.
module tb_text_console_frame_writer;

  localparam int PAGES       = 16;
  localparam int COLUMNS     = 256;
  localparam int GLYPH_WIDTH = 5;

  localparam int          RANDOM_REQUESTS = 600;
  localparam int          WAIT_IDLE_AT    = 360;     // sender drains the block here
  localparam int unsigned HOLD_AFTER      = 250;     // receiver freezes after this result
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int          TAIL_CYCLES     = 20;
  localparam int          CYCLE_LIMIT     = 1_500_000;
  localparam int          MAX_REPORTS     = 40;
  localparam logic [2:0]  REQ_UNUSED      = 3'd7;    // highest undecoded request code

  // One pending transaction for the sender; wait_idle holds it back until
  // every earlier result has been seen.
  typedef struct {
    tcfw_pkg::in_item_t req;
    bit                 wait_idle;
  } queued_req_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  tcfw_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  tcfw_pkg::out_item_t out_data;

  queued_req_t         request_q[$];
  tcfw_pkg::out_item_t cursor_reports_q[$];     // expected results, oldest first

  // Console mirror: framebuffer, font and cursor as the block should hold them
  logic [7:0]  fb_model   [PAGES*COLUMNS];
  logic [7:0]  font_model [tcfw_pkg::GLYPH_COUNT*GLYPH_WIDTH];
  logic [4:0]  cur_page;
  logic [7:0]  cur_col;

  // Generator-side bookkeeping: which font bytes have been loaded so far
  bit          font_written [tcfw_pkg::GLYPH_COUNT*GLYPH_WIDTH];
  bit          hold_next;
  logic [7:0]  probe_row;

  int unsigned accepted_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned send_gap = 0;
  int unsigned stall_cnt = 0;
  int unsigned send_calm = 0;
  int unsigned recv_calm = 0;
  int unsigned error_cnt = 0;
  int unsigned drawn_cnt = 0;
  int unsigned dropped_cnt = 0;
  int unsigned clear_cnt = 0;
  int unsigned read_hit_cnt = 0;
  int unsigned cycle_cnt = 0;

  text_console_frame_writer #(
    .PAGES      (PAGES),
    .COLUMNS    (COLUMNS),
    .GLYPH_WIDTH(GLYPH_WIDTH)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Console predictor
  // ---------------------------------------------------------------------------

  // Page advance saturates at PAGES, which marks the cursor as off screen
  function automatic void next_page();
    if (cur_page < PAGES) cur_page = cur_page + 5'd1;
    cur_col = '0;
  endfunction

  function automatic tcfw_pkg::out_item_t apply_console_request(tcfw_pkg::in_item_t r);
    tcfw_pkg::out_item_t res;
    int                  base;
    int                  gbase;
    res = '0;
    case (r.req_type)
      tcfw_pkg::REQ_CHAR: begin
        if (r.char_code == tcfw_pkg::NEWLINE_CODE) begin
          next_page();
        end else if (r.char_code >= tcfw_pkg::FIRST_CODE &&
                     r.char_code <= tcfw_pkg::LAST_CODE) begin
          // wrap first unless the cell ends short of the last column of this page
          if (int'(cur_col) + GLYPH_WIDTH + 1 >= COLUMNS) next_page();
          if (cur_page < PAGES) begin
            base  = int'(cur_page) * COLUMNS + int'(cur_col);
            gbase = (int'(r.char_code) - int'(tcfw_pkg::FIRST_CODE)) * GLYPH_WIDTH;
            for (int i = 0; i < GLYPH_WIDTH; i++) fb_model[base + i] = font_model[gbase + i];
            fb_model[base + GLYPH_WIDTH] = tcfw_pkg::BLANK_COLUMN;
            cur_col = cur_col + 8'(GLYPH_WIDTH + 1);
            drawn_cnt++;
          end else begin
            dropped_cnt++;
          end
        end
      end
      tcfw_pkg::REQ_CURSOR: begin
        if (r.row < PAGES && r.column < COLUMNS) begin
          cur_page = 5'(r.row);
          cur_col  = 8'(r.column);
        end
      end
      tcfw_pkg::REQ_CLEAR: begin
        foreach (fb_model[i]) fb_model[i] = '0;
        cur_page = '0;
        cur_col  = '0;
        clear_cnt++;
      end
      tcfw_pkg::REQ_LOAD: begin
        if (r.glyph_index < tcfw_pkg::GLYPH_COUNT && r.glyph_column < GLYPH_WIDTH)
          font_model[int'(r.glyph_index) * GLYPH_WIDTH + int'(r.glyph_column)] = r.glyph_byte;
      end
      tcfw_pkg::REQ_READ: begin
        if (r.row < PAGES && r.column < COLUMNS) begin
          res.read_data = fb_model[int'(r.row) * COLUMNS + int'(r.column)];
          if (res.read_data != '0) read_hit_cnt++;
        end
      end
      default: ;
    endcase
    res.text_row = cur_page;
    res.text_col = cur_col;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Every field random, so unused fields still toggle all their bits
  function automatic tcfw_pkg::in_item_t random_fill();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(tcfw_pkg::in_item_t)-1:0];
  endfunction

  // Idle length for either side: mostly none, some short, a few long, and
  // now and then a calm stretch with no idling at all
  function automatic int unsigned pick_idle(inout int unsigned calm_left);
    int unsigned roll;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic queue_request(tcfw_pkg::in_item_t r);
    request_q.push_back('{req: r, wait_idle: hold_next});
    hold_next = 1'b0;
  endtask

  task automatic queue_at(logic [2:0] kind, logic [7:0] row, logic [8:0] col);
    tcfw_pkg::in_item_t r;
    r          = random_fill();
    r.req_type = kind;
    r.row      = row;
    r.column   = col;
    queue_request(r);
  endtask

  task automatic queue_load(logic [6:0] gidx, logic [2:0] gcol, logic [7:0] gbyte);
    tcfw_pkg::in_item_t r;
    r              = random_fill();
    r.req_type     = tcfw_pkg::REQ_LOAD;
    r.glyph_index  = gidx;
    r.glyph_column = gcol;
    r.glyph_byte   = gbyte;
    if (gidx < tcfw_pkg::GLYPH_COUNT && gcol < GLYPH_WIDTH)
      font_written[int'(gidx) * GLYPH_WIDTH + int'(gcol)] = 1'b1;
    queue_request(r);
  endtask

  // A printable character never reaches the block before its whole glyph is
  // loaded: missing font bytes go in first with random content.
  task automatic queue_char(logic [7:0] code);
    tcfw_pkg::in_item_t r;
    int                 g;
    if (code >= tcfw_pkg::FIRST_CODE && code <= tcfw_pkg::LAST_CODE) begin
      g = int'(code) - int'(tcfw_pkg::FIRST_CODE);
      for (int c = 0; c < GLYPH_WIDTH; c++)
        if (!font_written[g * GLYPH_WIDTH + c])
          queue_load(7'(g), 3'(c), 8'($urandom));
    end
    r           = random_fill();
    r.req_type  = tcfw_pkg::REQ_CHAR;
    r.char_code = code;
    queue_request(r);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: offers queued transactions, predicts each one as it is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    logic               took;
    logic               valid_next;
    tcfw_pkg::in_item_t data_next;
    int unsigned        gap_next;
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_data      <= '0;
      send_gap     <= 0;
      accepted_cnt <= 0;
    end else begin
      took       = in_valid && !in_stall;
      valid_next = in_valid && !took;
      data_next  = in_data;
      gap_next   = send_gap;
      if (took) begin
        cursor_reports_q.push_back(apply_console_request(in_data));
        accepted_cnt <= accepted_cnt + 1;
        gap_next = pick_idle(send_calm);
      end
      // counters are compared at their pre-edge values, so a drain point
      // waits until the block has handed back everything it took
      if (!valid_next) begin
        if (gap_next > 0) begin
          gap_next--;
        end else if (request_q.size() != 0 &&
                     !(request_q[0].wait_idle && (took || accepted_cnt != checked_cnt))) begin
          data_next  = request_q[0].req;
          void'(request_q.pop_front());
          valid_next = 1'b1;
        end
      end
      in_valid <= valid_next;
      in_data  <= data_next;
      send_gap <= gap_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: checks each result transaction and stalls at random; once, it
  // freezes long enough for the block to back up and stall its input
  // ---------------------------------------------------------------------------
  function automatic void compare_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      error_cnt++;
      if (error_cnt <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk or negedge rst_n) begin
    logic                took;
    tcfw_pkg::out_item_t want;
    int unsigned         stall_next;
    if (!rst_n) begin
      out_stall   <= 1'b0;
      stall_cnt   <= 0;
      checked_cnt <= 0;
    end else begin
      took       = out_valid && !out_stall;
      stall_next = stall_cnt;
      if (took) begin
        if (cursor_reports_q.size() == 0) begin
          error_cnt++;
          if (error_cnt <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        end else begin
          want = cursor_reports_q.pop_front();
          compare_field("read_data", want.read_data, out_data.read_data);
          compare_field("text_row", 8'(want.text_row), 8'(out_data.text_row));
          compare_field("text_col", want.text_col, out_data.text_col);
        end
        checked_cnt <= checked_cnt + 1;
        stall_next = (checked_cnt + 1 == HOLD_AFTER) ? HOLD_CYCLES : pick_idle(recv_calm);
      end
      if (stall_next > 0) begin
        out_stall <= 1'b1;
        stall_cnt <= stall_next - 1;
      end else begin
        out_stall <= 1'b0;
        stall_cnt <= 0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL text_console_frame_writer");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int          pick;
    int unsigned sub;
    logic [7:0]  code;
    logic [2:0]  kind;

    foreach (fb_model[i]) fb_model[i] = '0;
    foreach (font_model[i]) font_model[i] = '0;
    foreach (font_written[i]) font_written[i] = 1'b0;
    cur_page  = '0;
    cur_col   = '0;
    hold_next = 1'b0;
    probe_row = '0;

    // Directed: corners of the character set, wrapping, the off-screen page,
    // rejected cursor moves, reads and loads, an undecoded request and clear
    queue_at(tcfw_pkg::REQ_READ, 8'd0, 9'd0);
    queue_load(7'h7F, 3'(GLYPH_WIDTH - 1), 8'hFF);         // glyph index past the font
    queue_load(7'(tcfw_pkg::GLYPH_COUNT - 1), 3'h7, 8'hFF); // column past the glyph
    queue_char(tcfw_pkg::FIRST_CODE);
    queue_char(tcfw_pkg::LAST_CODE);
    queue_char(tcfw_pkg::FIRST_CODE - 8'd1);               // non-printable, ignored
    queue_char(tcfw_pkg::LAST_CODE + 8'd1);
    queue_char(8'hFF);
    queue_char(tcfw_pkg::NEWLINE_CODE);
    queue_at(tcfw_pkg::REQ_READ, 8'd0, 9'(GLYPH_WIDTH + 1)); // first byte of the second cell
    queue_at(tcfw_pkg::REQ_CURSOR, 8'(PAGES - 2), 9'(COLUMNS - GLYPH_WIDTH - 1));
    queue_char(tcfw_pkg::LAST_CODE);                       // wraps onto the last page
    queue_at(tcfw_pkg::REQ_CURSOR, 8'(PAGES - 1), 9'(COLUMNS - GLYPH_WIDTH - 2));
    queue_char(tcfw_pkg::LAST_CODE);                       // just fits at the right edge
    queue_char(tcfw_pkg::FIRST_CODE);                      // wraps off screen, dropped
    queue_char(tcfw_pkg::NEWLINE_CODE);                    // page stays saturated
    queue_at(tcfw_pkg::REQ_CURSOR, 8'(PAGES), 9'd0);
    queue_at(tcfw_pkg::REQ_CURSOR, 8'd0, 9'(COLUMNS));
    queue_at(tcfw_pkg::REQ_READ, 8'(PAGES - 1), 9'(COLUMNS - 3));
    queue_at(tcfw_pkg::REQ_READ, 8'(PAGES - 1), 9'(COLUMNS - 1));
    queue_at(tcfw_pkg::REQ_READ, 8'(PAGES), 9'd0);
    queue_at(tcfw_pkg::REQ_READ, 8'd0, 9'(COLUMNS));
    queue_at(REQ_UNUSED, 8'd0, 9'd0);
    queue_at(tcfw_pkg::REQ_CLEAR, 8'd0, 9'd0);
    queue_at(tcfw_pkg::REQ_READ, 8'd0, 9'(GLYPH_WIDTH + 1));

    // Random: mostly text with cursor moves and read-back, some noise
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == WAIT_IDLE_AT) hold_next = 1'b1;
      pick = $urandom_range(0, 99);
      sub  = $urandom_range(0, 9);
      if (pick < 45) begin
        queue_char(8'($urandom_range(tcfw_pkg::FIRST_CODE, tcfw_pkg::LAST_CODE)));
      end else if (pick < 50) begin
        queue_char(tcfw_pkg::NEWLINE_CODE);
      end else if (pick < 55) begin
        do code = 8'($urandom);
        while ((code >= tcfw_pkg::FIRST_CODE && code <= tcfw_pkg::LAST_CODE) ||
               code == tcfw_pkg::NEWLINE_CODE);
        queue_char(code);
      end else if (pick < 67) begin
        if (sub < 6) begin
          probe_row = 8'($urandom_range(0, PAGES - 1));
          queue_at(tcfw_pkg::REQ_CURSOR, probe_row, 9'($urandom_range(0, COLUMNS - 1)));
        end else if (sub < 8) begin
          // close to the right edge or on the last page, to force wraps
          probe_row = (sub == 6) ? 8'(PAGES - 1) : 8'($urandom_range(0, PAGES - 1));
          queue_at(tcfw_pkg::REQ_CURSOR, probe_row,
                   9'($urandom_range(COLUMNS - 2 * (GLYPH_WIDTH + 1), COLUMNS - 1)));
        end else begin
          queue_at(tcfw_pkg::REQ_CURSOR, 8'($urandom), 9'($urandom));
        end
      end else if (pick < 68) begin
        queue_at(tcfw_pkg::REQ_CLEAR, 8'($urandom), 9'($urandom));
      end else if (pick < 76) begin
        if (sub < 7)
          queue_load(7'($urandom_range(0, tcfw_pkg::GLYPH_COUNT - 1)),
                     3'($urandom_range(0, GLYPH_WIDTH - 1)), 8'($urandom));
        else
          queue_load(7'($urandom), 3'($urandom), 8'($urandom));
      end else if (pick < 96) begin
        if (sub < 5)
          queue_at(tcfw_pkg::REQ_READ, probe_row, 9'($urandom_range(0, COLUMNS - 1)));
        else if (sub < 9)
          queue_at(tcfw_pkg::REQ_READ, 8'($urandom_range(0, PAGES - 1)),
                   9'($urandom_range(0, COLUMNS - 1)));
        else
          queue_at(tcfw_pkg::REQ_READ, 8'($urandom), 9'($urandom));
      end else begin
        do kind = 3'($urandom);
        while (kind <= tcfw_pkg::REQ_READ);
        queue_at(kind, 8'($urandom), 9'($urandom));
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || in_valid) @(posedge clk);
    while (checked_cnt != accepted_cnt) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (cursor_reports_q.size() != 0) begin
      error_cnt += cursor_reports_q.size();
      $display("%0t: %0d results never arrived", $time, cursor_reports_q.size());
    end
    $display("Run: %0d transactions checked, %0d glyphs drawn, %0d dropped off screen",
             checked_cnt, drawn_cnt, dropped_cnt);
    $display("Run: %0d clears, %0d non-zero read-backs, %0d mismatches",
             clear_cnt, read_hit_cnt, error_cnt);
    if (error_cnt == 0) begin
      $display("PASS text_console_frame_writer");
    end else begin
      $display("FAIL text_console_frame_writer");
    end
    $finish;
  end

endmodule
